@@ hdl/tpmq_pkg.sv @@
package tpmq_pkg;

  localparam int NODE_W = 10;
  localparam int WT_W   = 32;

  localparam logic signed [WT_W-1:0] WT_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_CLEAR,
    FUNC_LOAD,
    FUNC_BUILD,
    FUNC_QUERY
  } func_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_DISC = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_CLR,
    S_ROOT_RD,
    S_ROOT_CHK,
    S_POP,
    S_POP_WT,
    S_DU,
    S_EDGE_RD,
    S_EDGE_EV,
    S_VIS_CHK,
    S_BDONE,
    S_QDA,
    S_QDB,
    S_QSTEP,
    S_QUP,
    S_RESP
  } state_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_CLEAR,
    OP_LOAD,
    OP_BLD_START,
    OP_CLR_STEP,
    OP_ROOT_RD,
    OP_ROOT_NEXT,
    OP_ROOT_INIT,
    OP_POP,
    OP_U_LATCH,
    OP_DU_LATCH,
    OP_EDGE_RD,
    OP_EDGE_EV,
    OP_VIS_CHK,
    OP_BLD_FIN,
    OP_Q_CHECK,
    OP_Q_DA,
    OP_Q_DB,
    OP_Q_OK,
    OP_Q_DISC,
    OP_Q_RD,
    OP_Q_UP,
    OP_RESP
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  clr_last;
    logic  root_vis;
    logic  root_last;
    logic  q_empty;
    logic  ei_end;
    logic  edge_hit;
    logic  q_bad;
    logic  q_eq;
    logic  q_root;
    logic  out_free;
  } dp_stat_t;

endpackage

@@ hdl/tpmq_if.sv @@
interface tpmq_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic [tpmq_pkg::NODE_W-1:0] node_a;
  logic [tpmq_pkg::NODE_W-1:0] node_b;
  logic signed [tpmq_pkg::WT_W-1:0] edge_weight;

  modport source (output valid, func, node_a, node_b, edge_weight, input ready);
  modport sink   (input valid, func, node_a, node_b, edge_weight, output ready);
endinterface

interface tpmq_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [tpmq_pkg::WT_W-1:0] min_weight;
  logic [1:0]                     status;

  modport source (output valid, min_weight, status, input ready);
  modport sink   (input valid, min_weight, status, output ready);
endinterface

@@ hdl/tpmq_ctrl.sv @@
module tpmq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tpmq_pkg::dp_stat_t stat_i,
  output tpmq_pkg::dp_cmd_t  cmd_o
);

  tpmq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpmq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = tpmq_pkg::OP_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      tpmq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = tpmq_pkg::OP_LATCH;
          state_d  = tpmq_pkg::S_DISP;
        end
      end
      tpmq_pkg::S_DISP: begin
        case (stat_i.func)
          tpmq_pkg::FUNC_CLEAR: begin
            cmd_o.op = tpmq_pkg::OP_CLEAR;
            state_d  = tpmq_pkg::S_RESP;
          end
          tpmq_pkg::FUNC_LOAD: begin
            cmd_o.op = tpmq_pkg::OP_LOAD;
            state_d  = tpmq_pkg::S_RESP;
          end
          tpmq_pkg::FUNC_BUILD: begin
            cmd_o.op = tpmq_pkg::OP_BLD_START;
            state_d  = tpmq_pkg::S_CLR;
          end
          default: begin
            cmd_o.op = tpmq_pkg::OP_Q_CHECK;
            state_d  = stat_i.q_bad ? tpmq_pkg::S_RESP : tpmq_pkg::S_QDA;
          end
        endcase
      end
      tpmq_pkg::S_CLR: begin
        cmd_o.op = tpmq_pkg::OP_CLR_STEP;
        if (stat_i.clr_last) state_d = tpmq_pkg::S_ROOT_RD;
      end
      tpmq_pkg::S_ROOT_RD: begin
        cmd_o.op = tpmq_pkg::OP_ROOT_RD;
        state_d  = tpmq_pkg::S_ROOT_CHK;
      end
      tpmq_pkg::S_ROOT_CHK: begin
        if (stat_i.root_vis) begin
          cmd_o.op = tpmq_pkg::OP_ROOT_NEXT;
          state_d  = stat_i.root_last ? tpmq_pkg::S_BDONE : tpmq_pkg::S_ROOT_RD;
        end else begin
          cmd_o.op = tpmq_pkg::OP_ROOT_INIT;
          state_d  = tpmq_pkg::S_POP;
        end
      end
      tpmq_pkg::S_POP: begin
        if (stat_i.q_empty) begin
          cmd_o.op = tpmq_pkg::OP_ROOT_NEXT;
          state_d  = stat_i.root_last ? tpmq_pkg::S_BDONE : tpmq_pkg::S_ROOT_RD;
        end else begin
          cmd_o.op = tpmq_pkg::OP_POP;
          state_d  = tpmq_pkg::S_POP_WT;
        end
      end
      tpmq_pkg::S_POP_WT: begin
        cmd_o.op = tpmq_pkg::OP_U_LATCH;
        state_d  = tpmq_pkg::S_DU;
      end
      tpmq_pkg::S_DU: begin
        cmd_o.op = tpmq_pkg::OP_DU_LATCH;
        state_d  = tpmq_pkg::S_EDGE_RD;
      end
      tpmq_pkg::S_EDGE_RD: begin
        if (stat_i.ei_end) begin
          state_d = tpmq_pkg::S_POP;
        end else begin
          cmd_o.op = tpmq_pkg::OP_EDGE_RD;
          state_d  = tpmq_pkg::S_EDGE_EV;
        end
      end
      tpmq_pkg::S_EDGE_EV: begin
        cmd_o.op = tpmq_pkg::OP_EDGE_EV;
        state_d  = stat_i.edge_hit ? tpmq_pkg::S_VIS_CHK : tpmq_pkg::S_EDGE_RD;
      end
      tpmq_pkg::S_VIS_CHK: begin
        cmd_o.op = tpmq_pkg::OP_VIS_CHK;
        state_d  = tpmq_pkg::S_EDGE_RD;
      end
      tpmq_pkg::S_BDONE: begin
        cmd_o.op = tpmq_pkg::OP_BLD_FIN;
        state_d  = tpmq_pkg::S_RESP;
      end
      tpmq_pkg::S_QDA: begin
        cmd_o.op = tpmq_pkg::OP_Q_DA;
        state_d  = tpmq_pkg::S_QDB;
      end
      tpmq_pkg::S_QDB: begin
        cmd_o.op = tpmq_pkg::OP_Q_DB;
        state_d  = tpmq_pkg::S_QSTEP;
      end
      tpmq_pkg::S_QSTEP: begin
        if (stat_i.q_eq) begin
          cmd_o.op = tpmq_pkg::OP_Q_OK;
          state_d  = tpmq_pkg::S_RESP;
        end else if (stat_i.q_root) begin
          cmd_o.op = tpmq_pkg::OP_Q_DISC;
          state_d  = tpmq_pkg::S_RESP;
        end else begin
          cmd_o.op = tpmq_pkg::OP_Q_RD;
          state_d  = tpmq_pkg::S_QUP;
        end
      end
      tpmq_pkg::S_QUP: begin
        cmd_o.op = tpmq_pkg::OP_Q_UP;
        state_d  = tpmq_pkg::S_QSTEP;
      end
      tpmq_pkg::S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.op = tpmq_pkg::OP_RESP;
          state_d  = tpmq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tpmq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/tpmq_dp.sv @@
module tpmq_dp #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tpmq_pkg::dp_cmd_t                 cmd_i,
  output tpmq_pkg::dp_stat_t                stat_o,
  input  logic [1:0]                        func_i,
  input  logic [tpmq_pkg::NODE_W-1:0]       node_a_i,
  input  logic [tpmq_pkg::NODE_W-1:0]       node_b_i,
  input  logic signed [tpmq_pkg::WT_W-1:0]  edge_weight_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [tpmq_pkg::WT_W-1:0]  min_weight_o,
  output logic [1:0]                        status_o
);

  localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int XW    = ((VW > tpmq_pkg::NODE_W) ? VW : tpmq_pkg::NODE_W) + 1;
  localparam int EDGES = MAX_VERTICES - 1;
  localparam int NW    = tpmq_pkg::NODE_W;
  localparam int WW    = tpmq_pkg::WT_W;

  // memories
  logic [NW-1:0]        mem_ea [EDGES];
  logic [NW-1:0]        mem_eb [EDGES];
  logic signed [WW-1:0] mem_ew [EDGES];
  logic                 mem_vis [MAX_VERTICES];
  logic [VW-1:0]        mem_par [MAX_VERTICES];
  logic signed [WW-1:0] mem_pw  [MAX_VERTICES];
  logic [VW-1:0]        mem_dep [MAX_VERTICES];
  logic [VW-1:0]        mem_que [MAX_VERTICES];

  logic [NW-1:0]        ea_rd, eb_rd;
  logic signed [WW-1:0] ew_rd, pw_rd;
  logic                 vis_rd;
  logic [VW-1:0]        par_rd, dep_rd, que_rd;

  // control registers
  logic [VW-1:0]        ec_q;
  logic                 built_q;
  logic                 out_valid_q;
  logic [VW:0]          head_q, tail_q;

  // payload registers
  tpmq_pkg::func_e      func_q;
  logic [NW-1:0]        a_q, b_q;
  logic signed [WW-1:0] w_q, res_w_q, best_q, tw_q, out_w_q;
  logic [1:0]           res_st_q, out_st_q;
  logic [VW-1:0]        clr_q, root_q, ei_q, u_q, v_q, du_q, dv_q, to_q;

  tpmq_pkg::op_e op;
  assign op = cmd_i.op;

  logic [XW-1:0] nv_x, a_x, b_x, ea_x, eb_x, u_x;
  logic          full, q_bad, hit_a, hit_b, in_rng, edge_hit, new_vis, deep_u;
  logic [VW-1:0] to_sel, deep, shallow, dmax, dmin;

  assign nv_x  = {{(XW-VW){1'b0}}, ec_q} + XW'(1);
  assign a_x   = {{(XW-NW){1'b0}}, a_q};
  assign b_x   = {{(XW-NW){1'b0}}, b_q};
  assign ea_x  = {{(XW-NW){1'b0}}, ea_rd};
  assign eb_x  = {{(XW-NW){1'b0}}, eb_rd};
  assign u_x   = {{(XW-VW){1'b0}}, u_q};
  assign full  = (ec_q == VW'(EDGES));
  assign q_bad = !built_q || (a_q == b_q) || (a_x >= nv_x) || (b_x >= nv_x);

  assign in_rng   = (ea_x < nv_x) && (eb_x < nv_x);
  assign hit_a    = (ea_x == u_x);
  assign hit_b    = (eb_x == u_x);
  assign edge_hit = in_rng && (hit_a || hit_b);
  assign to_sel   = hit_a ? eb_x[VW-1:0] : ea_x[VW-1:0];
  assign new_vis  = (op == tpmq_pkg::OP_VIS_CHK) && !vis_rd;

  // climb from the deeper endpoint; ties climb v
  assign deep_u  = (du_q > dv_q);
  assign deep    = deep_u ? u_q : v_q;
  assign shallow = deep_u ? v_q : u_q;
  assign dmax    = deep_u ? du_q : dv_q;
  assign dmin    = deep_u ? dv_q : du_q;

  assign stat_o.func      = func_q;
  assign stat_o.clr_last  = (clr_q == ec_q);
  assign stat_o.root_vis  = vis_rd;
  assign stat_o.root_last = (root_q == ec_q);
  assign stat_o.q_empty   = (head_q == tail_q);
  assign stat_o.ei_end    = (ei_q == ec_q);
  assign stat_o.edge_hit  = edge_hit;
  assign stat_o.q_bad     = q_bad;
  assign stat_o.q_eq      = (u_q == v_q);
  assign stat_o.q_root    = (dmax == '0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign min_weight_o = out_w_q;
  assign status_o     = out_st_q;

  // memory ports
  logic          vis_we, vis_wd, tree_we;
  logic [VW-1:0] vis_wa, vis_ra, tree_wa, par_wd, dep_wd, dep_ra, que_wa, que_wd;
  logic signed [WW-1:0] pw_wd;

  always_comb begin
    vis_we  = 1'b0;
    vis_wa  = to_q;
    vis_wd  = 1'b1;
    tree_we = 1'b0;
    tree_wa = to_q;
    par_wd  = u_q;
    pw_wd   = tw_q;
    dep_wd  = du_q + 1'b1;
    que_wa  = tail_q[VW-1:0];
    que_wd  = to_q;
    vis_ra  = (op == tpmq_pkg::OP_EDGE_EV) ? to_sel : root_q;
    dep_ra  = a_q[VW-1:0] & '1;
    case (op)
      tpmq_pkg::OP_CLR_STEP: begin
        vis_we = 1'b1;
        vis_wa = clr_q;
        vis_wd = 1'b0;
      end
      tpmq_pkg::OP_ROOT_INIT: begin
        vis_we  = 1'b1;
        vis_wa  = root_q;
        tree_we = 1'b1;
        tree_wa = root_q;
        par_wd  = root_q;
        pw_wd   = '0;
        dep_wd  = '0;
        que_wa  = '0;
        que_wd  = root_q;
      end
      tpmq_pkg::OP_VIS_CHK: begin
        vis_we  = new_vis;
        tree_we = new_vis;
      end
      default: begin
      end
    endcase
    case (op)
      tpmq_pkg::OP_U_LATCH: dep_ra = que_rd;
      tpmq_pkg::OP_Q_DA:    dep_ra = b_x[VW-1:0];
      default:              dep_ra = a_x[VW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (op == tpmq_pkg::OP_LOAD && !full) begin
      mem_ea[ec_q] <= a_q;
      mem_eb[ec_q] <= b_q;
      mem_ew[ec_q] <= w_q;
    end
    ea_rd <= mem_ea[ei_q];
    eb_rd <= mem_eb[ei_q];
    ew_rd <= mem_ew[ei_q];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) mem_vis[vis_wa] <= vis_wd;
    vis_rd <= mem_vis[vis_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      mem_par[tree_wa] <= par_wd;
      mem_pw[tree_wa]  <= pw_wd;
      mem_dep[tree_wa] <= dep_wd;
    end
    par_rd <= mem_par[deep];
    pw_rd  <= mem_pw[deep];
    dep_rd <= mem_dep[dep_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tree_we) mem_que[que_wa] <= que_wd;
    que_rd <= mem_que[head_q[VW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q        <= '0;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (op)
        tpmq_pkg::OP_CLEAR: begin
          ec_q    <= '0;
          built_q <= 1'b0;
        end
        tpmq_pkg::OP_LOAD: begin
          if (!full) begin
            ec_q    <= ec_q + 1'b1;
            built_q <= 1'b0;
          end
        end
        tpmq_pkg::OP_ROOT_INIT: begin
          head_q <= '0;
          tail_q <= (VW+1)'(1);
        end
        tpmq_pkg::OP_POP:     head_q <= head_q + 1'b1;
        tpmq_pkg::OP_VIS_CHK: if (new_vis) tail_q <= tail_q + 1'b1;
        tpmq_pkg::OP_BLD_FIN: built_q <= 1'b1;
        tpmq_pkg::OP_RESP:    out_valid_q <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      tpmq_pkg::OP_LATCH: begin
        func_q   <= tpmq_pkg::func_e'(func_i);
        a_q      <= node_a_i;
        b_q      <= node_b_i;
        w_q      <= edge_weight_i;
        res_w_q  <= '0;
        res_st_q <= tpmq_pkg::ST_OK;
      end
      tpmq_pkg::OP_LOAD:      if (full) res_st_q <= tpmq_pkg::ST_FULL;
      tpmq_pkg::OP_BLD_START: begin
        clr_q  <= '0;
        root_q <= '0;
      end
      tpmq_pkg::OP_CLR_STEP:  clr_q <= clr_q + 1'b1;
      tpmq_pkg::OP_ROOT_NEXT: root_q <= root_q + 1'b1;
      tpmq_pkg::OP_U_LATCH:   u_q <= que_rd;
      tpmq_pkg::OP_DU_LATCH: begin
        du_q <= dep_rd;
        ei_q <= '0;
      end
      tpmq_pkg::OP_EDGE_EV: begin
        to_q <= to_sel;
        tw_q <= ew_rd;
        ei_q <= ei_q + 1'b1;
      end
      tpmq_pkg::OP_Q_CHECK: begin
        u_q    <= a_x[VW-1:0];
        v_q    <= b_x[VW-1:0];
        best_q <= tpmq_pkg::WT_MAX;
        if (q_bad) res_st_q <= tpmq_pkg::ST_BAD;
      end
      tpmq_pkg::OP_Q_DA:   du_q <= dep_rd;
      tpmq_pkg::OP_Q_DB:   dv_q <= dep_rd;
      tpmq_pkg::OP_Q_OK:   res_w_q <= best_q;
      tpmq_pkg::OP_Q_DISC: res_st_q <= tpmq_pkg::ST_DISC;
      tpmq_pkg::OP_Q_RD: begin
        u_q  <= shallow;
        v_q  <= deep;
        du_q <= dmin;
        dv_q <= dmax;
      end
      tpmq_pkg::OP_Q_UP: begin
        v_q  <= par_rd;
        dv_q <= dv_q - 1'b1;
        if (pw_rd < best_q) best_q <= pw_rd;
      end
      tpmq_pkg::OP_RESP: begin
        out_w_q  <= res_w_q;
        out_st_q <= res_st_q;
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_ec_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ec_q <= VW'(EDGES))
    else $error("edge count beyond store depth");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("search queue head passed tail");

  a_built_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(built_q) |-> $past(op) == tpmq_pkg::OP_BLD_FIN)
    else $error("tree marked built outside build completion");
`endif

endmodule

@@ hdl/tree_path_min_query.sv @@
// Path-minimum query engine over a weighted forest.
// in_i carries one command per transfer: clear, load edge, build, or query.
// out_o returns exactly one result per command, in order: min_weight is the
// smallest edge weight on the query path (zero otherwise), status flags a
// full edge store, a bad or unbuilt query, or disconnected endpoints.
// One command is processed at a time; in_i.ready is high only when idle.
// A query climbs the tree one level per read of the parent memory. A build
// scans the edge memory for every dequeued vertex, NV vertices and E stored
// edges; it starts with a pass that clears NV visited marks.
// Reset empties the edge store and drops the built flag.
// A stalled receiver holds the result in the output register; the block
// then waits before finishing the next command.
module tree_path_min_query #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tpmq_in_if.sink       in_i,
  tpmq_out_if.source    out_o
);

  tpmq_pkg::dp_cmd_t  cmd;
  tpmq_pkg::dp_stat_t stat;

  tpmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tpmq_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .func_i        (in_i.func),
    .node_a_i      (in_i.node_a),
    .node_b_i      (in_i.node_b),
    .edge_weight_i (in_i.edge_weight),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .min_weight_o  (out_o.min_weight),
    .status_o      (out_o.status)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int NV_MAX = 1024;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    tpmq_pkg::func_e                  func;
    logic [tpmq_pkg::NODE_W-1:0]      a;
    logic [tpmq_pkg::NODE_W-1:0]      b;
    logic signed [tpmq_pkg::WT_W-1:0] w;
    bit                               drain;
  } cmd_t;

  typedef struct {
    logic signed [tpmq_pkg::WT_W-1:0] min_w;
    logic [1:0]                       st;
  } answer_t;

  logic clk;
  logic rst_n;

  tpmq_in_if  in_if ();
  tpmq_out_if out_if ();

  tree_path_min_query uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cmd_t    pending_cmds[$];
  answer_t expected_answers[$];
  cmd_t    cur_cmd;
  int      mismatches;
  int      cycles;
  int      answers_seen;

  // Shadow copy of the edge store and the rooted forest
  logic [tpmq_pkg::NODE_W-1:0]      edge_a[NV_MAX];
  logic [tpmq_pkg::NODE_W-1:0]      edge_b[NV_MAX];
  logic signed [tpmq_pkg::WT_W-1:0] edge_w[NV_MAX];
  int                               edge_cnt;
  bit                               forest_ok;
  int                               up_node[NV_MAX];
  int                               level[NV_MAX];
  logic signed [tpmq_pkg::WT_W-1:0] up_w[NV_MAX];

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic void build_forest_model();
    bit seen[NV_MAX];
    int fifo[NV_MAX];
    int nv, head, tail, u, x, y, nxt;
    nv = edge_cnt + 1;
    for (int i = 0; i < NV_MAX; i++) seen[i] = 1'b0;
    for (int r = 0; r < nv; r++) begin
      if (seen[r]) continue;
      seen[r] = 1'b1;
      level[r] = 0;
      up_node[r] = r;
      up_w[r] = '0;
      head = 0;
      tail = 0;
      fifo[tail++] = r;
      while (head < tail) begin
        u = fifo[head++];
        for (int i = 0; i < edge_cnt; i++) begin
          x = int'(edge_a[i]);
          y = int'(edge_b[i]);
          if (x >= nv || y >= nv) continue;
          if (x == u) nxt = y;
          else if (y == u) nxt = x;
          else continue;
          if (seen[nxt]) continue;
          seen[nxt] = 1'b1;
          level[nxt] = level[u] + 1;
          up_node[nxt] = u;
          up_w[nxt] = edge_w[i];
          if (tail < NV_MAX) fifo[tail++] = nxt;
        end
      end
    end
    forest_ok = 1'b1;
  endfunction

  function automatic answer_t path_min_model(int u, int v);
    answer_t r;
    int nv, t, steps;
    logic signed [tpmq_pkg::WT_W-1:0] best;
    nv = edge_cnt + 1;
    best = tpmq_pkg::WT_MAX;
    steps = 0;
    r.min_w = '0;
    if (!forest_ok || u == v || u >= nv || v >= nv) begin
      r.st = tpmq_pkg::ST_BAD;
      return r;
    end
    while (u != v) begin
      if (level[u] > level[v]) begin
        t = u;
        u = v;
        v = t;
      end
      if (level[v] == 0 || steps > 2 * NV_MAX) begin
        r.st = tpmq_pkg::ST_DISC;
        return r;
      end
      if (up_w[v] < best) best = up_w[v];
      v = up_node[v];
      steps++;
    end
    r.st = tpmq_pkg::ST_OK;
    r.min_w = best;
    return r;
  endfunction

  function automatic answer_t apply_cmd(cmd_t c);
    answer_t r;
    r.min_w = '0;
    r.st = tpmq_pkg::ST_OK;
    case (c.func)
      tpmq_pkg::FUNC_CLEAR: begin
        edge_cnt = 0;
        forest_ok = 1'b0;
      end
      tpmq_pkg::FUNC_LOAD: begin
        if (edge_cnt >= NV_MAX - 1) begin
          r.st = tpmq_pkg::ST_FULL;
        end else begin
          edge_a[edge_cnt] = c.a;
          edge_b[edge_cnt] = c.b;
          edge_w[edge_cnt] = c.w;
          edge_cnt++;
          forest_ok = 1'b0;
        end
      end
      tpmq_pkg::FUNC_BUILD: build_forest_model();
      default: r = path_min_model(int'(c.a), int'(c.b));
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, answer_t got, answer_t want);
    mismatches++;
    $display("ERROR at cycle %0d: %s got min %0d st %0d, want min %0d st %0d",
             cycles, what, got.min_w, got.st, want.min_w, want.st);
  endtask

  // sender: drop valid only between transfers, hold the item until taken
  int  send_gap;
  bit  send_quiet;
  always @(posedge clk) begin
    bit take, nxt_valid;
    answer_t ans;
    take = in_if.valid && in_if.ready;
    send_quiet = pending_cmds.size() < 200;
    if (take) begin
      ans = apply_cmd(cur_cmd);
      expected_answers.push_back(ans);
    end
    if (rst_n && (!in_if.valid || take)) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_cmds.size() == 0) begin
        nxt_valid = 1'b0;
      end else if (pending_cmds[0].drain && expected_answers.size() != 0) begin
        nxt_valid = 1'b0;
      end else if (!send_quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 19) - 1;
      end else begin
        cur_cmd = pending_cmds.pop_front();
        nxt_valid = 1'b1;
        in_if.func <= cur_cmd.func;
        in_if.node_a <= cur_cmd.a;
        in_if.node_b <= cur_cmd.b;
        in_if.edge_weight <= cur_cmd.w;
      end
      in_if.valid <= nxt_valid;
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  int  recv_gap;
  int  hold_cnt;
  bit  held_once;
  always @(posedge clk) begin
    answer_t got, want;
    if (out_if.valid && out_if.ready) begin
      got.min_w = out_if.min_weight;
      got.st = out_if.status;
      answers_seen++;
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected result transfer", got, got);
      end else begin
        want = expected_answers.pop_front();
        if (got.min_w !== want.min_w) report_mismatch("min_weight", got, want);
        if (got.st !== want.st) report_mismatch("status", got, want);
      end
    end
    if (rst_n) begin
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else if (answers_seen >= 300 && !held_once) begin
        held_once = 1'b1;
        hold_cnt = 400;
        out_if.ready <= 1'b0;
      end else if (send_quiet) begin
        out_if.ready <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 19) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_cmd(tpmq_pkg::func_e f, int a, int b,
                          logic signed [tpmq_pkg::WT_W-1:0] w,
                          bit drain = 1'b0);
    cmd_t c;
    c.func = f;
    c.a = a[tpmq_pkg::NODE_W-1:0];
    c.b = b[tpmq_pkg::NODE_W-1:0];
    c.w = w;
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  function automatic logic signed [tpmq_pkg::WT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return tpmq_pkg::WT_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // clear, load a random tree (sometimes broken), usually build, then query it
  task automatic push_tree_sequence(inout int sent);
    int k, p, x, y, nq;
    push_cmd(tpmq_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom,
             $urandom_range(0, 15) == 0);
    k = $urandom_range(1, 20);
    for (int i = 0; i < k; i++) begin
      p = $urandom_range(0, i);
      case ($urandom_range(0, 11))
        0: begin x = $urandom_range(0, 1023); y = p; end
        1: begin x = p; y = p; end
        2: begin x = $urandom_range(0, i + 1); y = $urandom_range(0, i + 1); end
        default: begin x = i + 1; y = p; end
      endcase
      if ($urandom_range(0, 1)) push_cmd(tpmq_pkg::FUNC_LOAD, x, y, pick_weight());
      else push_cmd(tpmq_pkg::FUNC_LOAD, y, x, pick_weight());
    end
    sent += k + 1;
    if ($urandom_range(0, 7) != 0) begin
      push_cmd(tpmq_pkg::FUNC_BUILD, $urandom, $urandom, $urandom);
      sent++;
    end
    nq = $urandom_range(3, 12);
    for (int q = 0; q < nq; q++) begin
      case ($urandom_range(0, 15))
        0: push_cmd(tpmq_pkg::FUNC_QUERY, $urandom, $urandom, $urandom);
        1: begin
          x = $urandom_range(0, k);
          push_cmd(tpmq_pkg::FUNC_QUERY, x, x, $urandom);
        end
        2: push_cmd(tpmq_pkg::FUNC_LOAD, $urandom_range(0, k), $urandom_range(0, k + 1),
                    pick_weight());
        3: push_cmd(tpmq_pkg::FUNC_QUERY, $urandom_range(0, k + 2),
                    $urandom_range(0, 1023), $urandom);
        default: push_cmd(tpmq_pkg::FUNC_QUERY, $urandom_range(0, k),
                          $urandom_range(0, k), $urandom);
      endcase
      sent++;
    end
    if ($urandom_range(0, 9) == 0) begin
      for (int n = 0; n < 3; n++)
        push_cmd(tpmq_pkg::func_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
      sent += 3;
    end
  endtask

  initial begin
    int sent;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.func = tpmq_pkg::FUNC_CLEAR;
    in_if.node_a = '0;
    in_if.node_b = '0;
    in_if.edge_weight = '0;
    out_if.ready = 1'b0;
    mismatches = 0;
    cycles = 0;
    answers_seen = 0;
    edge_cnt = 0;
    forest_ok = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    hold_cnt = 0;
    held_once = 1'b0;

    // directed: unbuilt and bad queries, extremes, stray edges, load after build
    push_cmd(tpmq_pkg::FUNC_QUERY, 0, 1, '0);
    push_cmd(tpmq_pkg::FUNC_BUILD, 0, 0, '0);
    push_cmd(tpmq_pkg::FUNC_QUERY, 0, 0, '0);
    push_cmd(tpmq_pkg::FUNC_LOAD, 0, 1, 32'sh8000_0000);
    push_cmd(tpmq_pkg::FUNC_LOAD, 1, 2, tpmq_pkg::WT_MAX);
    push_cmd(tpmq_pkg::FUNC_LOAD, 3, 2, 0);
    push_cmd(tpmq_pkg::FUNC_LOAD, 1023, 0, -1);
    push_cmd(tpmq_pkg::FUNC_LOAD, 3, 3, 5);
    push_cmd(tpmq_pkg::FUNC_LOAD, 1, 0, 7);
    push_cmd(tpmq_pkg::FUNC_QUERY, 0, 3, '0);
    push_cmd(tpmq_pkg::FUNC_BUILD, 1023, 1023, -1);
    push_cmd(tpmq_pkg::FUNC_QUERY, 0, 3, '0);
    push_cmd(tpmq_pkg::FUNC_QUERY, 3, 1, -1);
    push_cmd(tpmq_pkg::FUNC_QUERY, 2, 1, '0);
    push_cmd(tpmq_pkg::FUNC_QUERY, 2, 2, '0);
    push_cmd(tpmq_pkg::FUNC_QUERY, 0, 1023, '0);
    push_cmd(tpmq_pkg::FUNC_QUERY, 7, 0, '0);
    push_cmd(tpmq_pkg::FUNC_QUERY, 5, 0, '0);
    push_cmd(tpmq_pkg::FUNC_QUERY, 6, 5, '0);
    push_cmd(tpmq_pkg::FUNC_LOAD, 6, 5, 9);
    push_cmd(tpmq_pkg::FUNC_QUERY, 0, 1, '0);
    push_cmd(tpmq_pkg::FUNC_CLEAR, 1023, 1023, -1);
    push_cmd(tpmq_pkg::FUNC_QUERY, 0, 1, '0);

    // fill the edge store, then overflow it; never build this one
    push_cmd(tpmq_pkg::FUNC_CLEAR, 0, 0, '0, 1'b1);
    for (int i = 0; i < NV_MAX - 1; i++)
      push_cmd(tpmq_pkg::FUNC_LOAD, $urandom, $urandom, $urandom);
    push_cmd(tpmq_pkg::FUNC_LOAD, 1, 2, 3);
    push_cmd(tpmq_pkg::FUNC_QUERY, 1, 2, '0);
    push_cmd(tpmq_pkg::FUNC_CLEAR, 0, 0, '0, 1'b1);

    sent = pending_cmds.size();
    while (sent < 1750) push_tree_sequence(sent);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    forever begin
      @(posedge clk);
      if (pending_cmds.size() == 0 && !in_if.valid && expected_answers.size() == 0)
        break;
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
